// ===== rtl/hkm_pkg.sv =====
`timescale 1ns / 1ps
package hkm_pkg;

   localparam int VERTICES_DEF  = 32;
   localparam int MAX_EDGES_DEF = 256;
   localparam int VERT_W        = 5;
   localparam int SIZE_W        = 6;
   localparam int CSR_W         = 5;
   localparam int REQ_TDATA_W   = 16;
   localparam int RSP_TDATA_W   = 24;

   // Datapath operations issued by the controller, at most one per cycle.
   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_INIT_STEP,
      OP_BFS_POP,
      OP_BFS_READ,
      OP_BFS_CHECK,
      OP_AUG_START,
      OP_ROOT_SKIP,
      OP_ROOT_PUSH,
      OP_DFS_POP,
      OP_DFS_READ,
      OP_DFS_ADV,
      OP_DFS_PUSH,
      OP_UNW_READ,
      OP_UNW_WRITE,
      OP_ROOT_FOUND,
      OP_PHASE_END,
      OP_OUT_START,
      OP_EMIT
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic v_past_top;
      logic root_matched;
      logic queue_empty;
      logic scan_done;
      logic ptr_done;
      logic edge_hit;
      logic right_free;
      logic can_push;
      logic sp_one;
      logic sp_zero;
      logic found_zero;
      logic emit_ready;
      logic emit_last;
   } status_type;

endpackage

// ===== rtl/bipartite_matching_hopcroft_karp_unit.sv =====
`timescale 1ns / 1ps
// Maximum bipartite matching by Hopcroft-Karp. Each request item loads one edge (left, right)
// into an edge memory in arrival order; edges with an endpoint at or beyond VERTICES are
// ignored, and edges past MAX_EDGES are dropped and reported through edge_overflow. Items are
// loaded as they are accepted and may arrive back to back. The item with tlast set starts a
// run over left vertices 0..last_left_vertex (saturated to VERTICES-1); no request is taken
// until the run has handed all its results to the output register. A run repeats phases: a
// breadth-first layering steps over vertices 0..top, then reads and checks every stored edge
// for each queued vertex; the depth-first augmentation reads and checks the edge at each
// edge-pointer step and rewrites the matching for each vertex on a found path. The edge memory
// is read one word per cycle with registered data. After the run one response item per left
// vertex is emitted, one per cycle when the consumer keeps tready high, the final one marked by
// tlast. The csr channel is always ready and should only be written while the block is idle.
module bipartite_matching_hopcroft_karp_unit #(
   parameter int VERTICES  = hkm_pkg::VERTICES_DEF,
   parameter int MAX_EDGES = hkm_pkg::MAX_EDGES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // req_tdata: left_vertex[4:0], right_vertex[9:5], edge_valid[10], zero fill
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [hkm_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  logic                            req_tlast,
   // rsp_tdata: vertex_index[4:0], partner[9:5], partner_valid[10],
   // matching_size[16:11], edge_overflow[17], zero fill
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [hkm_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic                            rsp_tlast,
   // csr_data: last_left_vertex
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [hkm_pkg::CSR_W-1:0]       csr_data
);
   import hkm_pkg::*;

   cmd_type          cmd;
   status_type       status;
   logic [CSR_W-1:0] last_left_ff;

   // The configuration register is a plain holding register.
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) last_left_ff <= '0;
      else if (csr_valid) last_left_ff <= csr_data;
   end

   hkm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   hkm_dp #(
      .VERTICES  (VERTICES),
      .MAX_EDGES (MAX_EDGES)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .left_vertex      (req_tdata[4:0]),
      .right_vertex     (req_tdata[9:5]),
      .edge_valid       (req_tdata[10]),
      .last             (req_tlast),
      .last_left_vertex (last_left_ff),
      .rsp_tready       (rsp_tready),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tdata        (rsp_tdata),
      .rsp_tlast        (rsp_tlast)
   );

endmodule

// ===== rtl/hkm_ctrl.sv =====
`timescale 1ns / 1ps
module hkm_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   input  logic                req_tlast,
   output logic                req_tready,
   input  hkm_pkg::status_type status,
   output hkm_pkg::cmd_type    cmd
);
   import hkm_pkg::*;

   typedef enum logic [11:0] {
      S_IDLE      = 12'b0000_0000_0001,
      S_INIT      = 12'b0000_0000_0010,
      S_BFS_POP   = 12'b0000_0000_0100,
      S_BFS_RD    = 12'b0000_0000_1000,
      S_BFS_CHK   = 12'b0000_0001_0000,
      S_AUG_START = 12'b0000_0010_0000,
      S_AUG_NEXT  = 12'b0000_0100_0000,
      S_DFS_TOP   = 12'b0000_1000_0000,
      S_DFS_CHK   = 12'b0001_0000_0000,
      S_UNW_RD    = 12'b0010_0000_0000,
      S_UNW_WR    = 12'b0100_0000_0000,
      S_EMIT      = 12'b1000_0000_0000
   } state_type;

   state_type state_ff, state_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd.op   = OP_NONE;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.op = OP_LOAD;
               if (req_tlast) state_in = S_INIT;
            end
         end
         S_INIT: begin
            if (status.v_past_top) state_in = S_BFS_POP;
            else cmd.op = OP_INIT_STEP;
         end
         S_BFS_POP: begin
            if (status.queue_empty) begin
               state_in = S_AUG_START;
            end else begin
               cmd.op   = OP_BFS_POP;
               state_in = S_BFS_RD;
            end
         end
         S_BFS_RD: begin
            if (status.scan_done) begin
               state_in = S_BFS_POP;
            end else begin
               cmd.op   = OP_BFS_READ;
               state_in = S_BFS_CHK;
            end
         end
         S_BFS_CHK: begin
            cmd.op   = OP_BFS_CHECK;
            state_in = S_BFS_RD;
         end
         S_AUG_START: begin
            cmd.op   = OP_AUG_START;
            state_in = S_AUG_NEXT;
         end
         S_AUG_NEXT: begin
            if (status.v_past_top) begin
               if (status.found_zero) begin
                  cmd.op   = OP_OUT_START;
                  state_in = S_EMIT;
               end else begin
                  cmd.op   = OP_PHASE_END;
                  state_in = S_INIT;
               end
            end else if (status.root_matched) begin
               cmd.op = OP_ROOT_SKIP;
            end else begin
               cmd.op   = OP_ROOT_PUSH;
               state_in = S_DFS_TOP;
            end
         end
         S_DFS_TOP: begin
            if (status.ptr_done) begin
               cmd.op = OP_DFS_POP;
               if (status.sp_one) state_in = S_AUG_NEXT;
            end else begin
               cmd.op   = OP_DFS_READ;
               state_in = S_DFS_CHK;
            end
         end
         S_DFS_CHK: begin
            state_in = S_DFS_TOP;
            if (!status.edge_hit) cmd.op = OP_DFS_ADV;
            else if (status.right_free) state_in = S_UNW_RD;
            else if (status.can_push) cmd.op = OP_DFS_PUSH;
            else cmd.op = OP_DFS_ADV;
         end
         S_UNW_RD: begin
            if (status.sp_zero) begin
               cmd.op   = OP_ROOT_FOUND;
               state_in = S_AUG_NEXT;
            end else begin
               cmd.op   = OP_UNW_READ;
               state_in = S_UNW_WR;
            end
         end
         S_UNW_WR: begin
            cmd.op   = OP_UNW_WRITE;
            state_in = S_UNW_RD;
         end
         S_EMIT: begin
            if (status.emit_ready) begin
               cmd.op = OP_EMIT;
               if (status.emit_last) state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

endmodule

// ===== rtl/hkm_dp.sv =====
`timescale 1ns / 1ps
module hkm_dp #(
   parameter int VERTICES  = hkm_pkg::VERTICES_DEF,
   parameter int MAX_EDGES = hkm_pkg::MAX_EDGES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  hkm_pkg::cmd_type                cmd,
   output hkm_pkg::status_type             status,
   input  logic [hkm_pkg::VERT_W-1:0]      left_vertex,
   input  logic [hkm_pkg::VERT_W-1:0]      right_vertex,
   input  logic                            edge_valid,
   input  logic                            last,
   input  logic [hkm_pkg::CSR_W-1:0]       last_left_vertex,
   input  logic                            rsp_tready,
   output logic                            rsp_tvalid,
   output logic [hkm_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic                            rsp_tlast
);
   import hkm_pkg::*;

   localparam int VW = $clog2(VERTICES);
   localparam int CW = VW + 1;
   localparam int DW = VW + 1;
   localparam int AW = $clog2(MAX_EDGES);
   localparam int EW = $clog2(MAX_EDGES + 1);
   localparam logic [DW-1:0] FAR_LAYER = '1;

   logic [2*VW-1:0] edge_mem [MAX_EDGES];
   logic [2*VW-1:0] rd_data_ff;
   logic [AW-1:0]   rd_addr;
   logic            rd_en;

   logic [EW-1:0] edge_cnt_ff;
   logic          ovf_ff;
   logic [VW-1:0] top_ff;
   logic [VW-1:0] lp_ff    [VERTICES];
   logic [VW-1:0] rp_ff    [VERTICES];
   logic [VERTICES-1:0] rm_ff, lm_ff;
   logic [DW-1:0] dist_ff  [VERTICES];
   logic [EW-1:0] ep_ff    [VERTICES];
   logic [VW-1:0] queue_ff [VERTICES];
   logic [VW-1:0] stack_ff [VERTICES];
   logic [CW-1:0] v_ff, head_ff, tail_ff, sp_ff, found_ff, total_ff;
   logic [EW-1:0] k_ff;
   logic [VW-1:0] s_ff, t_ff;

   logic              out_valid_ff;
   logic [VERT_W-1:0] out_index_ff, out_partner_ff;
   logic              out_pv_ff, out_ovf_ff, out_last_ff;
   logic [SIZE_W-1:0] out_size_ff;

   logic [VW-1:0] v_idx, s_top, below_top, el, er, w, lv, rv;
   logic [CW-1:0] sp_m1, sp_m2;
   logic [EW-1:0] cur_ptr;
   logic [VW-1:0] top_c;
   logic          load_edge, bfs_take;

   assign v_idx     = v_ff[VW-1:0];
   assign sp_m1     = sp_ff - 1'b1;
   assign sp_m2     = sp_ff - CW'(2);
   assign s_top     = stack_ff[sp_m1[VW-1:0]];
   assign below_top = stack_ff[sp_m2[VW-1:0]];
   assign cur_ptr   = ep_ff[s_top];
   assign el        = rd_data_ff[VW-1:0];
   assign er        = rd_data_ff[2*VW-1:VW];
   assign w         = rp_ff[er];
   assign lv        = VW'(left_vertex);
   assign rv        = VW'(right_vertex);
   assign top_c     = (32'(last_left_vertex) < VERTICES) ? VW'(last_left_vertex)
                                                         : VW'(VERTICES - 1);
   assign load_edge = edge_valid && (32'(left_vertex) < VERTICES)
                      && (32'(right_vertex) < VERTICES);
   assign bfs_take  = (el == s_ff) && rm_ff[er] && (w <= top_ff)
                      && (dist_ff[w] == FAR_LAYER) && (tail_ff < CW'(VERTICES));

   always_comb begin
      status.v_past_top   = v_ff > CW'(top_ff);
      status.root_matched = lm_ff[v_idx];
      status.queue_empty  = head_ff == tail_ff;
      status.scan_done    = k_ff == edge_cnt_ff;
      status.ptr_done     = cur_ptr >= edge_cnt_ff;
      status.edge_hit     = el == s_top;
      status.right_free   = !rm_ff[er];
      status.can_push     = (w <= top_ff) && (dist_ff[w] == DW'(dist_ff[s_top] + 1'b1))
                            && (sp_ff < CW'(VERTICES));
      status.sp_one       = sp_ff == CW'(1);
      status.sp_zero      = sp_ff == '0;
      status.found_zero   = found_ff == '0;
      status.emit_ready   = !out_valid_ff || rsp_tready;
      status.emit_last    = v_idx == top_ff;
   end

   always_comb begin
      rd_en   = 1'b0;
      rd_addr = '0;
      case (cmd.op)
         OP_BFS_READ: begin rd_en = 1'b1; rd_addr = AW'(k_ff);    end
         OP_DFS_READ: begin rd_en = 1'b1; rd_addr = AW'(cur_ptr); end
         OP_UNW_READ: begin rd_en = 1'b1; rd_addr = AW'(cur_ptr); end
         default: rd_en = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_LOAD && load_edge && edge_cnt_ff < EW'(MAX_EDGES))
         edge_mem[edge_cnt_ff[AW-1:0]] <= {rv, lv};
      if (rd_en) rd_data_ff <= edge_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         edge_cnt_ff  <= '0;
         ovf_ff       <= 1'b0;
         rm_ff        <= '0;
         lm_ff        <= '0;
         out_valid_ff <= 1'b0;
         v_ff         <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         sp_ff        <= '0;
         found_ff     <= '0;
         total_ff     <= '0;
         k_ff         <= '0;
         top_ff       <= '0;
      end else begin
         if (cmd.op != OP_EMIT && out_valid_ff && rsp_tready) out_valid_ff <= 1'b0;
         case (cmd.op)
            OP_LOAD: begin
               if (load_edge) begin
                  if (edge_cnt_ff < EW'(MAX_EDGES)) edge_cnt_ff <= edge_cnt_ff + 1'b1;
                  else ovf_ff <= 1'b1;
               end
               if (last) begin
                  top_ff   <= top_c;
                  rm_ff    <= '0;
                  lm_ff    <= '0;
                  total_ff <= '0;
                  v_ff     <= '0;
                  head_ff  <= '0;
                  tail_ff  <= '0;
               end
            end
            OP_INIT_STEP: begin
               if (lm_ff[v_idx]) begin
                  dist_ff[v_idx] <= FAR_LAYER;
               end else begin
                  dist_ff[v_idx]              <= '0;
                  queue_ff[tail_ff[VW-1:0]]   <= v_idx;
                  tail_ff                     <= tail_ff + 1'b1;
               end
               v_ff <= v_ff + 1'b1;
            end
            OP_BFS_POP: begin
               s_ff    <= queue_ff[head_ff[VW-1:0]];
               head_ff <= head_ff + 1'b1;
               k_ff    <= '0;
            end
            OP_BFS_READ: k_ff <= k_ff + 1'b1;
            OP_BFS_CHECK: begin
               if (bfs_take) begin
                  dist_ff[w]                <= DW'(dist_ff[s_ff] + 1'b1);
                  queue_ff[tail_ff[VW-1:0]] <= w;
                  tail_ff                   <= tail_ff + 1'b1;
               end
            end
            OP_AUG_START: begin
               for (int i = 0; i < VERTICES; i++) ep_ff[i] <= '0;
               v_ff     <= '0;
               found_ff <= '0;
            end
            OP_ROOT_SKIP: v_ff <= v_ff + 1'b1;
            OP_ROOT_PUSH: begin
               stack_ff[0] <= v_idx;
               sp_ff       <= CW'(1);
            end
            OP_DFS_POP: begin
               sp_ff <= sp_m1;
               if (sp_ff == CW'(1)) v_ff <= v_ff + 1'b1;
               else ep_ff[below_top] <= ep_ff[below_top] + 1'b1;
            end
            OP_DFS_ADV: ep_ff[s_top] <= cur_ptr + 1'b1;
            OP_DFS_PUSH: begin
               stack_ff[sp_ff[VW-1:0]] <= w;
               sp_ff                   <= sp_ff + 1'b1;
            end
            OP_UNW_READ: begin
               t_ff  <= s_top;
               sp_ff <= sp_m1;
            end
            OP_UNW_WRITE: begin
               lp_ff[t_ff] <= er;
               rp_ff[er]   <= t_ff;
               rm_ff[er]   <= 1'b1;
               lm_ff[t_ff] <= 1'b1;
            end
            OP_ROOT_FOUND: begin
               found_ff <= found_ff + 1'b1;
               v_ff     <= v_ff + 1'b1;
            end
            OP_PHASE_END: begin
               total_ff <= total_ff + found_ff;
               v_ff     <= '0;
               head_ff  <= '0;
               tail_ff  <= '0;
            end
            OP_OUT_START: v_ff <= '0;
            OP_EMIT: begin
               out_valid_ff   <= 1'b1;
               out_index_ff   <= VERT_W'(v_idx);
               out_partner_ff <= lm_ff[v_idx] ? VERT_W'(lp_ff[v_idx]) : '0;
               out_pv_ff      <= lm_ff[v_idx];
               out_size_ff    <= SIZE_W'(total_ff);
               out_ovf_ff     <= ovf_ff;
               out_last_ff    <= v_idx == top_ff;
               v_ff           <= v_ff + 1'b1;
               if (v_idx == top_ff) begin
                  edge_cnt_ff <= '0;
                  ovf_ff      <= 1'b0;
               end
            end
            default: v_ff <= v_ff;
         endcase
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {6'b0, out_ovf_ff, out_size_ff, out_pv_ff, out_partner_ff,
                        out_index_ff};

   a_stack_bound: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= CW'(VERTICES)) else $error("path stack overran");
   a_queue_order: assert property (@(posedge clock) disable iff (reset)
      head_ff <= tail_ff && tail_ff <= CW'(VERTICES)) else $error("search queue corrupt");
   a_edge_bound: assert property (@(posedge clock) disable iff (reset)
      edge_cnt_ff <= EW'(MAX_EDGES)) else $error("edge count beyond capacity");
   a_unwind_match: assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_UNW_WRITE |=> lm_ff[$past(t_ff)] && rm_ff[$past(er)])
      else $error("augmenting path not recorded");

endmodule
